>>> rtl/core/bwh_pkg.sv
package bwh_pkg;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;        // coordinate difference magnitude
  localparam int SQ_W     = 2 * DIFF_W;         // squared difference, also the sum of three
  localparam int LEN_W    = SQ_W / 2;           // floor sqrt of the squared distance
  localparam int FAC_W    = LEN_W + 2;          // magnitude of one heron factor
  localparam int PAIR_W   = 2 * FAC_W;          // product of two factors
  localparam int HALF_W   = PAIR_W / 2;         // split for the partial products
  localparam int PROD_W   = 2 * PAIR_W;         // full heron product
  localparam int AREA_W   = PROD_W / 2;         // four times the area, truncated

  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_W = 24;
  localparam int NUM_W    = AREA_W + WEIGHT_FRAC_BITS;
  localparam int CMP_W    = AREA_W + WEIGHT_W;

  localparam int NUM_PTS  = 4;
  localparam int NUM_LEN  = 6;
  localparam int NUM_AREA = 4;
  localparam int NUM_WT   = 3;

  localparam int LEN_LAT  = 3 + LEN_W;
  localparam int AREA_LAT = 4 + AREA_W;
  localparam int DIV_LAT  = 1 + WEIGHT_W;
  localparam int PIPE_LAT = LEN_LAT + AREA_LAT + DIV_LAT;

  // points: a, b, c, query
  localparam int PT_A = 0;
  localparam int PT_B = 1;
  localparam int PT_C = 2;
  localparam int PT_P = 3;

  // lengths: ab, bc, ca, pa, pb, pc
  localparam int LEN_END [NUM_LEN][2] = '{
    '{PT_A, PT_B}, '{PT_B, PT_C}, '{PT_C, PT_A},
    '{PT_A, PT_P}, '{PT_B, PT_P}, '{PT_C, PT_P}
  };

  // triangles: whole, opposite a, opposite b, opposite c
  localparam int TRI_LEN [NUM_AREA][3] = '{
    '{0, 1, 2}, '{1, 4, 5}, '{2, 3, 5}, '{0, 3, 4}
  };

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [AREA_W-1:0] area_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

>>> rtl/core/bwh_len.sv
module bwh_len (
  input  logic           clk,
  input  logic           en,
  input  bwh_pkg::vec3_t pts [bwh_pkg::NUM_PTS],
  output bwh_pkg::len_t  len [bwh_pkg::NUM_LEN]
);

  logic [bwh_pkg::DIFF_W-1:0] mag_r   [bwh_pkg::NUM_LEN][3];
  logic [bwh_pkg::DIFF_W-1:0] mag_nxt [bwh_pkg::NUM_LEN][3];
  logic [bwh_pkg::SQ_W-1:0]   sq_r    [bwh_pkg::NUM_LEN][3];
  logic [bwh_pkg::SQ_W-1:0]   sq_nxt  [bwh_pkg::NUM_LEN][3];

  logic [bwh_pkg::SQ_W-1:0]    rad_r    [bwh_pkg::NUM_LEN][bwh_pkg::LEN_W+1];
  logic [bwh_pkg::SQ_W-1:0]    rad_nxt  [bwh_pkg::NUM_LEN][bwh_pkg::LEN_W+1];
  logic [bwh_pkg::LEN_W+1:0]   rem_r    [bwh_pkg::NUM_LEN][bwh_pkg::LEN_W+1];
  logic [bwh_pkg::LEN_W+1:0]   rem_nxt  [bwh_pkg::NUM_LEN][bwh_pkg::LEN_W+1];
  logic [bwh_pkg::LEN_W-1:0]   root_r   [bwh_pkg::NUM_LEN][bwh_pkg::LEN_W+1];
  logic [bwh_pkg::LEN_W-1:0]   root_nxt [bwh_pkg::NUM_LEN][bwh_pkg::LEN_W+1];

  always_comb begin
    logic [bwh_pkg::DIFF_W-1:0]  diff;
    logic [bwh_pkg::LEN_W+3:0]   r2;
    logic [bwh_pkg::LEN_W+3:0]   trial;
    logic [bwh_pkg::LEN_W+3:0]   rdiff;
    bwh_pkg::coord_t             c0;
    bwh_pkg::coord_t             c1;
    for (int l = 0; l < bwh_pkg::NUM_LEN; l++) begin
      for (int k = 0; k < 3; k++) begin
        c0 = pts[bwh_pkg::LEN_END[l][0]][k];
        c1 = pts[bwh_pkg::LEN_END[l][1]][k];
        diff = {c1[bwh_pkg::COORD_W-1], c1} - {c0[bwh_pkg::COORD_W-1], c0};
        mag_nxt[l][k] = diff[bwh_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
        sq_nxt[l][k] = {{bwh_pkg::DIFF_W{1'b0}}, mag_r[l][k]}
                     * {{bwh_pkg::DIFF_W{1'b0}}, mag_r[l][k]};
      end
      rad_nxt[l][0]  = sq_r[l][0] + sq_r[l][1] + sq_r[l][2];
      rem_nxt[l][0]  = '0;
      root_nxt[l][0] = '0;
      // one root bit per stage, two radicand bits consumed
      for (int k = 0; k < bwh_pkg::LEN_W; k++) begin
        r2    = {rem_r[l][k], rad_r[l][k][bwh_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, root_r[l][k], 2'b01};
        rdiff = r2 - trial;
        rad_nxt[l][k+1] = {rad_r[l][k][bwh_pkg::SQ_W-3:0], 2'b00};
        if (r2 >= trial) begin
          rem_nxt[l][k+1]  = rdiff[bwh_pkg::LEN_W+1:0];
          root_nxt[l][k+1] = {root_r[l][k][bwh_pkg::LEN_W-2:0], 1'b1};
        end else begin
          rem_nxt[l][k+1]  = r2[bwh_pkg::LEN_W+1:0];
          root_nxt[l][k+1] = {root_r[l][k][bwh_pkg::LEN_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_nxt;
      sq_r   <= sq_nxt;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  always_comb begin
    for (int l = 0; l < bwh_pkg::NUM_LEN; l++) begin
      len[l] = root_r[l][bwh_pkg::LEN_W];
    end
  end

endmodule

>>> rtl/core/bwh_area.sv
module bwh_area (
  input  logic           clk,
  input  logic           en,
  input  bwh_pkg::len_t  len  [bwh_pkg::NUM_LEN],
  output bwh_pkg::area_t area [bwh_pkg::NUM_AREA]
);

  logic [bwh_pkg::FAC_W-1:0]  fac_r    [bwh_pkg::NUM_AREA][4];
  logic [bwh_pkg::FAC_W-1:0]  fac_nxt  [bwh_pkg::NUM_AREA][4];
  logic [bwh_pkg::PAIR_W-1:0] pair_r   [bwh_pkg::NUM_AREA][2];
  logic [bwh_pkg::PAIR_W-1:0] pair_nxt [bwh_pkg::NUM_AREA][2];
  logic [bwh_pkg::PAIR_W-1:0] part_r   [bwh_pkg::NUM_AREA][4];
  logic [bwh_pkg::PAIR_W-1:0] part_nxt [bwh_pkg::NUM_AREA][4];
  logic [2:0]                 neg_r    [bwh_pkg::NUM_AREA];
  logic [2:0]                 neg_nxt  [bwh_pkg::NUM_AREA];

  logic [bwh_pkg::PROD_W-1:0]  rad_r    [bwh_pkg::NUM_AREA][bwh_pkg::AREA_W+1];
  logic [bwh_pkg::PROD_W-1:0]  rad_nxt  [bwh_pkg::NUM_AREA][bwh_pkg::AREA_W+1];
  logic [bwh_pkg::AREA_W+1:0]  rem_r    [bwh_pkg::NUM_AREA][bwh_pkg::AREA_W+1];
  logic [bwh_pkg::AREA_W+1:0]  rem_nxt  [bwh_pkg::NUM_AREA][bwh_pkg::AREA_W+1];
  logic [bwh_pkg::AREA_W-1:0]  root_r   [bwh_pkg::NUM_AREA][bwh_pkg::AREA_W+1];
  logic [bwh_pkg::AREA_W-1:0]  root_nxt [bwh_pkg::NUM_AREA][bwh_pkg::AREA_W+1];

  always_comb begin
    logic [bwh_pkg::FAC_W:0]     ea;
    logic [bwh_pkg::FAC_W:0]     eb;
    logic [bwh_pkg::FAC_W:0]     ec;
    logic [bwh_pkg::FAC_W:0]     s    [4];
    logic [bwh_pkg::PAIR_W:0]    mid;
    logic [bwh_pkg::PROD_W-1:0]  prod;
    logic [bwh_pkg::AREA_W+3:0]  r2;
    logic [bwh_pkg::AREA_W+3:0]  trial;
    logic [bwh_pkg::AREA_W+3:0]  rdiff;
    for (int t = 0; t < bwh_pkg::NUM_AREA; t++) begin
      ea = {{(bwh_pkg::FAC_W+1-bwh_pkg::LEN_W){1'b0}}, len[bwh_pkg::TRI_LEN[t][0]]};
      eb = {{(bwh_pkg::FAC_W+1-bwh_pkg::LEN_W){1'b0}}, len[bwh_pkg::TRI_LEN[t][1]]};
      ec = {{(bwh_pkg::FAC_W+1-bwh_pkg::LEN_W){1'b0}}, len[bwh_pkg::TRI_LEN[t][2]]};
      s[0] = ea + eb + ec;
      s[1] = eb + ec - ea;
      s[2] = ea + ec - eb;
      s[3] = ea + eb - ec;
      for (int k = 0; k < 4; k++) begin
        fac_nxt[t][k] = s[k][bwh_pkg::FAC_W] ? (~s[k][bwh_pkg::FAC_W-1:0] + 1'b1)
                                               : s[k][bwh_pkg::FAC_W-1:0];
      end
      // sign of the product is the parity of the negative factors
      neg_nxt[t][0] = s[1][bwh_pkg::FAC_W] ^ s[2][bwh_pkg::FAC_W] ^ s[3][bwh_pkg::FAC_W];
      neg_nxt[t][1] = neg_r[t][0];
      neg_nxt[t][2] = neg_r[t][1];

      pair_nxt[t][0] = {{bwh_pkg::FAC_W{1'b0}}, fac_r[t][0]}
                     * {{bwh_pkg::FAC_W{1'b0}}, fac_r[t][1]};
      pair_nxt[t][1] = {{bwh_pkg::FAC_W{1'b0}}, fac_r[t][2]}
                     * {{bwh_pkg::FAC_W{1'b0}}, fac_r[t][3]};

      // partial products: low*low, low*high, high*low, high*high
      part_nxt[t][0] = {{bwh_pkg::HALF_W{1'b0}}, pair_r[t][0][bwh_pkg::HALF_W-1:0]}
                     * {{bwh_pkg::HALF_W{1'b0}}, pair_r[t][1][bwh_pkg::HALF_W-1:0]};
      part_nxt[t][1] = {{bwh_pkg::HALF_W{1'b0}}, pair_r[t][0][bwh_pkg::HALF_W-1:0]}
                     * {{bwh_pkg::HALF_W{1'b0}}, pair_r[t][1][bwh_pkg::PAIR_W-1:bwh_pkg::HALF_W]};
      part_nxt[t][2] = {{bwh_pkg::HALF_W{1'b0}}, pair_r[t][0][bwh_pkg::PAIR_W-1:bwh_pkg::HALF_W]}
                     * {{bwh_pkg::HALF_W{1'b0}}, pair_r[t][1][bwh_pkg::HALF_W-1:0]};
      part_nxt[t][3] = {{bwh_pkg::HALF_W{1'b0}}, pair_r[t][0][bwh_pkg::PAIR_W-1:bwh_pkg::HALF_W]}
                     * {{bwh_pkg::HALF_W{1'b0}}, pair_r[t][1][bwh_pkg::PAIR_W-1:bwh_pkg::HALF_W]};

      mid  = {1'b0, part_r[t][1]} + {1'b0, part_r[t][2]};
      prod = {part_r[t][3], part_r[t][0]}
           + bwh_pkg::PROD_W'({mid, {bwh_pkg::HALF_W{1'b0}}});
      rad_nxt[t][0]  = neg_r[t][2] ? '0 : prod;
      rem_nxt[t][0]  = '0;
      root_nxt[t][0] = '0;

      for (int k = 0; k < bwh_pkg::AREA_W; k++) begin
        r2    = {rem_r[t][k], rad_r[t][k][bwh_pkg::PROD_W-1 -: 2]};
        trial = {2'b00, root_r[t][k], 2'b01};
        rdiff = r2 - trial;
        rad_nxt[t][k+1] = {rad_r[t][k][bwh_pkg::PROD_W-3:0], 2'b00};
        if (r2 >= trial) begin
          rem_nxt[t][k+1]  = rdiff[bwh_pkg::AREA_W+1:0];
          root_nxt[t][k+1] = {root_r[t][k][bwh_pkg::AREA_W-2:0], 1'b1};
        end else begin
          rem_nxt[t][k+1]  = r2[bwh_pkg::AREA_W+1:0];
          root_nxt[t][k+1] = {root_r[t][k][bwh_pkg::AREA_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fac_r  <= fac_nxt;
      neg_r  <= neg_nxt;
      pair_r <= pair_nxt;
      part_r <= part_nxt;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  always_comb begin
    for (int t = 0; t < bwh_pkg::NUM_AREA; t++) begin
      area[t] = root_r[t][bwh_pkg::AREA_W];
    end
  end

endmodule

>>> rtl/core/bwh_div.sv
module bwh_div (
  input  logic             clk,
  input  logic             en,
  input  bwh_pkg::area_t   area   [bwh_pkg::NUM_AREA],
  output bwh_pkg::weight_t weight [bwh_pkg::NUM_WT],
  output logic             degenerate
);

  logic [bwh_pkg::AREA_W-1:0]   den_r    [bwh_pkg::WEIGHT_W+1];
  logic [bwh_pkg::AREA_W-1:0]   den_nxt  [bwh_pkg::WEIGHT_W+1];
  logic                         deg_r    [bwh_pkg::WEIGHT_W+1];
  logic                         deg_nxt  [bwh_pkg::WEIGHT_W+1];
  logic [bwh_pkg::NUM_W-1:0]    rem_r    [bwh_pkg::NUM_WT][bwh_pkg::WEIGHT_W+1];
  logic [bwh_pkg::NUM_W-1:0]    rem_nxt  [bwh_pkg::NUM_WT][bwh_pkg::WEIGHT_W+1];
  logic [bwh_pkg::WEIGHT_W-1:0] quo_r    [bwh_pkg::NUM_WT][bwh_pkg::WEIGHT_W+1];
  logic [bwh_pkg::WEIGHT_W-1:0] quo_nxt  [bwh_pkg::NUM_WT][bwh_pkg::WEIGHT_W+1];
  logic                         skip_r   [bwh_pkg::NUM_WT][bwh_pkg::WEIGHT_W+1];
  logic                         skip_nxt [bwh_pkg::NUM_WT][bwh_pkg::WEIGHT_W+1];

  always_comb begin
    logic [bwh_pkg::NUM_W-1:0] num;
    logic [bwh_pkg::CMP_W-1:0] trial;
    logic                      deg;
    logic                      sat;
    deg = (area[0] == '0);
    den_nxt[0] = area[0];
    deg_nxt[0] = deg;
    for (int k = 0; k < bwh_pkg::WEIGHT_W; k++) begin
      den_nxt[k+1] = den_r[k];
      deg_nxt[k+1] = deg_r[k];
    end
    for (int w = 0; w < bwh_pkg::NUM_WT; w++) begin
      num = {area[w+1], {bwh_pkg::WEIGHT_FRAC_BITS{1'b0}}};
      // quotient would not fit in the weight width
      sat = (bwh_pkg::CMP_W'(num) >= {area[0], {bwh_pkg::WEIGHT_W{1'b0}}});
      rem_nxt[w][0]  = num;
      skip_nxt[w][0] = deg | sat;
      quo_nxt[w][0]  = (!deg && sat) ? '1 : '0;
      // restoring division, one quotient bit per stage, msb first
      for (int k = 0; k < bwh_pkg::WEIGHT_W; k++) begin
        trial = bwh_pkg::CMP_W'(den_r[k]) << (bwh_pkg::WEIGHT_W - 1 - k);
        skip_nxt[w][k+1] = skip_r[w][k];
        rem_nxt[w][k+1]  = rem_r[w][k];
        quo_nxt[w][k+1]  = quo_r[w][k];
        if (!skip_r[w][k] && (bwh_pkg::CMP_W'(rem_r[w][k]) >= trial)) begin
          rem_nxt[w][k+1] = rem_r[w][k] - trial[bwh_pkg::NUM_W-1:0];
          quo_nxt[w][k+1][bwh_pkg::WEIGHT_W-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_nxt;
      deg_r  <= deg_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      skip_r <= skip_nxt;
    end
  end

  always_comb begin
    for (int w = 0; w < bwh_pkg::NUM_WT; w++) begin
      weight[w] = quo_r[w][bwh_pkg::WEIGHT_W];
    end
  end

  assign degenerate = deg_r[bwh_pkg::WEIGHT_W];

endmodule

>>> rtl/core/barycentric_weights_heron_core.sv
// Barycentric weights of a query point against a 3D triangle, by ratio of
// Heron areas. Input beat: the three vertices and the query point, each
// coordinate signed Q16.16. Output beat: three unsigned Q8.16 weights,
// saturating, and a degenerate flag (weights zero) when the triangle has
// no area. Both channels are valid/ready.
// Throughput: one beat per cycle while the spare output entry is empty.
// Pipeline depth: 36 stages for the six distances (differences, squares,
// sum, 33-step square root), 74 for the four areas (factors, two multiply
// stages, sum, 70-step square root) and 25 for the three quotients
// (saturation check, 24-step restoring division).
// Reset clears all valid bits; the datapath holds no state worth keeping.
// When the receiver stalls, a second output entry takes the beat leaving
// the pipeline, and the whole pipeline then holds until that entry drains;
// in_ready follows only that entry, so a stall costs no beat.
module barycentric_weights_heron_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       in_vert_a_x,
  input  logic signed [31:0]       in_vert_a_y,
  input  logic signed [31:0]       in_vert_a_z,
  input  logic signed [31:0]       in_vert_b_x,
  input  logic signed [31:0]       in_vert_b_y,
  input  logic signed [31:0]       in_vert_b_z,
  input  logic signed [31:0]       in_vert_c_x,
  input  logic signed [31:0]       in_vert_c_y,
  input  logic signed [31:0]       in_vert_c_z,
  input  logic signed [31:0]       in_point_x,
  input  logic signed [31:0]       in_point_y,
  input  logic signed [31:0]       in_point_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [23:0]              out_weight_a,
  output logic [23:0]              out_weight_b,
  output logic [23:0]              out_weight_c,
  output logic                     out_degenerate
);

  logic             en;
  bwh_pkg::vec3_t   pts    [bwh_pkg::NUM_PTS];
  bwh_pkg::len_t    len    [bwh_pkg::NUM_LEN];
  bwh_pkg::area_t   area   [bwh_pkg::NUM_AREA];
  bwh_pkg::weight_t weight [bwh_pkg::NUM_WT];
  logic             degenerate;

  logic [bwh_pkg::PIPE_LAT-1:0] vld_r;

  logic             out_valid_r;
  bwh_pkg::weight_t out_wt_r   [bwh_pkg::NUM_WT];
  logic             out_deg_r;
  logic             skid_full_r;
  bwh_pkg::weight_t skid_wt_r  [bwh_pkg::NUM_WT];
  logic             skid_deg_r;
  logic             take;
  logic             pipe_v;

  // pipeline advances unless the spare output entry is occupied
  assign en       = !skid_full_r;
  assign in_ready = en;

  assign pts[bwh_pkg::PT_A] = {in_vert_a_z, in_vert_a_y, in_vert_a_x};
  assign pts[bwh_pkg::PT_B] = {in_vert_b_z, in_vert_b_y, in_vert_b_x};
  assign pts[bwh_pkg::PT_C] = {in_vert_c_z, in_vert_c_y, in_vert_c_x};
  assign pts[bwh_pkg::PT_P] = {in_point_z, in_point_y, in_point_x};

  bwh_len u_len (
    .clk (clk),
    .en  (en),
    .pts (pts),
    .len (len)
  );

  bwh_area u_area (
    .clk  (clk),
    .en   (en),
    .len  (len),
    .area (area)
  );

  bwh_div u_div (
    .clk        (clk),
    .en         (en),
    .area       (area),
    .weight     (weight),
    .degenerate (degenerate)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[bwh_pkg::PIPE_LAT-2:0], in_valid};
    end
  end

  assign pipe_v = vld_r[bwh_pkg::PIPE_LAT-1];
  assign take   = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (take) begin
        skid_full_r <= 1'b0;
      end
    end else if (pipe_v) begin
      if (out_valid_r && !out_ready) begin
        skid_full_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (take) begin
        out_wt_r  <= skid_wt_r;
        out_deg_r <= skid_deg_r;
      end
    end else if (pipe_v) begin
      if (!out_valid_r || out_ready) begin
        out_wt_r  <= weight;
        out_deg_r <= degenerate;
      end else begin
        skid_wt_r  <= weight;
        skid_deg_r <= degenerate;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_weight_a   = out_wt_r[0];
  assign out_weight_b   = out_wt_r[1];
  assign out_weight_c   = out_wt_r[2];
  assign out_degenerate = out_deg_r;

  // spare entry only fills behind a held output beat
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("spare entry full with no output beat");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && !out_ready && pipe_v))
    else $error("spare entry filled without a stall");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_deg_r) |->
      (out_wt_r[0] == '0) && (out_wt_r[1] == '0) && (out_wt_r[2] == '0))
    else $error("degenerate beat with nonzero weights");

endmodule

>>> tb/bwh_checker.sv
module bwh_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  bwh_pkg::coord_t  in_vert_a_x,
  input  bwh_pkg::coord_t  in_vert_a_y,
  input  bwh_pkg::coord_t  in_vert_a_z,
  input  bwh_pkg::coord_t  in_vert_b_x,
  input  bwh_pkg::coord_t  in_vert_b_y,
  input  bwh_pkg::coord_t  in_vert_b_z,
  input  bwh_pkg::coord_t  in_vert_c_x,
  input  bwh_pkg::coord_t  in_vert_c_y,
  input  bwh_pkg::coord_t  in_vert_c_z,
  input  bwh_pkg::coord_t  in_point_x,
  input  bwh_pkg::coord_t  in_point_y,
  input  bwh_pkg::coord_t  in_point_z,
  input  logic             out_valid,
  input  logic             out_ready,
  input  bwh_pkg::weight_t out_weight_a,
  input  bwh_pkg::weight_t out_weight_b,
  input  bwh_pkg::weight_t out_weight_c,
  input  logic             out_degenerate,
  output int               errors,
  output int               backlog
);

  typedef struct {
    bwh_pkg::weight_t wa;
    bwh_pkg::weight_t wb;
    bwh_pkg::weight_t wc;
    logic             degen;
  } weights_t;

  weights_t weights_q[$];

  function automatic logic [255:0] floor_sqrt(input logic [255:0] n);
    logic [255:0] r;
    logic [255:0] t;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      t = r | (256'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [255:0] distance(input bwh_pkg::vec3_t p,
                                            input bwh_pkg::vec3_t q);
    logic [255:0] sum;
    longint d;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      d = longint'(q[k]) - longint'(p[k]);
      if (d < 0) d = -d;
      sum = sum + 256'(d) * 256'(d);
    end
    return floor_sqrt(sum);
  endfunction

  // four times the heron area, negative products clamp to zero
  function automatic logic [255:0] heron4(input longint a, input longint b, input longint c);
    longint f[4];
    logic [255:0] prod;
    bit neg;
    f[0] = a + b + c;
    f[1] = b + c - a;
    f[2] = a + c - b;
    f[3] = a + b - c;
    prod = 256'd1;
    neg = 0;
    for (int k = 0; k < 4; k++) begin
      if (f[k] < 0) begin
        neg = ~neg;
        f[k] = -f[k];
      end
      prod = prod * 256'(f[k]);
    end
    if (neg) prod = '0;
    return floor_sqrt(prod);
  endfunction

  function automatic bwh_pkg::weight_t ratio(input logic [255:0] num,
                                             input logic [255:0] den);
    logic [255:0] q;
    q = (num << bwh_pkg::WEIGHT_FRAC_BITS) / den;
    if (q > 256'(2**bwh_pkg::WEIGHT_W - 1)) q = 256'(2**bwh_pkg::WEIGHT_W - 1);
    return bwh_pkg::weight_t'(q);
  endfunction

  function automatic weights_t predict_weights(input bwh_pkg::vec3_t va,
                                               input bwh_pkg::vec3_t vb,
                                               input bwh_pkg::vec3_t vc,
                                               input bwh_pkg::vec3_t vp);
    weights_t w;
    longint ab, bc, ca, pa, pb, pc;
    logic [255:0] whole;
    ab = longint'(distance(va, vb));
    bc = longint'(distance(vb, vc));
    ca = longint'(distance(vc, va));
    pa = longint'(distance(va, vp));
    pb = longint'(distance(vb, vp));
    pc = longint'(distance(vc, vp));
    whole = heron4(ab, bc, ca);
    w = '{default: '0};
    if (whole == 0) begin
      w.degen = 1'b1;
    end else begin
      w.wa = ratio(heron4(bc, pb, pc), whole);
      w.wb = ratio(heron4(ca, pa, pc), whole);
      w.wc = ratio(heron4(ab, pa, pb), whole);
    end
    return w;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    weights_t w;
    if (!rst_n) begin
      errors = 0;
      backlog = 0;
    end else begin
      if (in_valid && in_ready)
        weights_q.push_back(predict_weights(
          {in_vert_a_z, in_vert_a_y, in_vert_a_x},
          {in_vert_b_z, in_vert_b_y, in_vert_b_x},
          {in_vert_c_z, in_vert_c_y, in_vert_c_x},
          {in_point_z, in_point_y, in_point_x}));
      if (out_valid && out_ready) begin
        if (weights_q.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          w = weights_q.pop_front();
          if (out_weight_a !== w.wa) report("weight_a", out_weight_a, w.wa);
          if (out_weight_b !== w.wb) report("weight_b", out_weight_b, w.wb);
          if (out_weight_c !== w.wc) report("weight_c", out_weight_c, w.wc);
          if (out_degenerate !== w.degen) report("degenerate", out_degenerate, w.degen);
        end
      end
      backlog = weights_q.size();
    end
  end

endmodule

>>> tb/tb_barycentric_weights_heron_core.sv
module tb_barycentric_weights_heron_core;

  localparam int RANDOM_ITEMS = 880;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bwh_pkg::coord_t tri_in [12];
  logic out_valid;
  logic out_ready;
  bwh_pkg::weight_t out_weight_a, out_weight_b, out_weight_c;
  logic out_degenerate;
  int errors, backlog;
  int sent;
  bit calm;
  bit hold_req;

  barycentric_weights_heron_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vert_a_x(tri_in[0]), .in_vert_a_y(tri_in[1]), .in_vert_a_z(tri_in[2]),
    .in_vert_b_x(tri_in[3]), .in_vert_b_y(tri_in[4]), .in_vert_b_z(tri_in[5]),
    .in_vert_c_x(tri_in[6]), .in_vert_c_y(tri_in[7]), .in_vert_c_z(tri_in[8]),
    .in_point_x(tri_in[9]), .in_point_y(tri_in[10]), .in_point_z(tri_in[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_weight_a(out_weight_a), .out_weight_b(out_weight_b),
    .out_weight_c(out_weight_c), .out_degenerate(out_degenerate)
  );

  bwh_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vert_a_x(tri_in[0]), .in_vert_a_y(tri_in[1]), .in_vert_a_z(tri_in[2]),
    .in_vert_b_x(tri_in[3]), .in_vert_b_y(tri_in[4]), .in_vert_b_z(tri_in[5]),
    .in_vert_c_x(tri_in[6]), .in_vert_c_y(tri_in[7]), .in_vert_c_z(tri_in[8]),
    .in_point_x(tri_in[9]), .in_point_y(tri_in[10]), .in_point_z(tri_in[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_weight_a(out_weight_a), .out_weight_b(out_weight_b),
    .out_weight_c(out_weight_c), .out_degenerate(out_degenerate),
    .errors(errors), .backlog(backlog)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_barycentric_weights_heron_core failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    bit held;
    out_ready = 0;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        hold = HOLD_CYCLES;
        held = 1;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
      end
    end
  end

  function automatic bwh_pkg::coord_t near(input bwh_pkg::coord_t base, input int shift);
    int off;
    off = int'($urandom_range((1 << shift) - 1)) - (1 << (shift - 1));
    return bwh_pkg::coord_t'(base + off);
  endfunction

  // one beat: hold valid until accepted, then maybe gap
  task automatic send(input bwh_pkg::coord_t item [12]);
    bit take;
    in_valid <= 1'b1;
    for (int k = 0; k < 12; k++) tri_in[k] <= item[k];
    do begin
      @(negedge clk);
      take = in_ready;
      @(posedge clk);
    end while (!take);
    sent++;
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 16);
    end
  endtask

  task automatic send_coords(input int ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz);
    bwh_pkg::coord_t item [12];
    item = '{ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz};
    send(item);
  endtask

  task automatic send_random();
    bwh_pkg::coord_t item [12];
    int kind, shift;
    kind = $urandom_range(99);
    shift = $urandom_range(2, 31);
    if (kind < 15) begin
      for (int k = 0; k < 12; k++) item[k] = bwh_pkg::coord_t'($urandom);
    end else begin
      for (int k = 0; k < 3; k++) item[k] = bwh_pkg::coord_t'($urandom);
      for (int k = 3; k < 12; k++) item[k] = near(item[k % 3], shift);
      if (kind < 25) begin
        // collinear: c mirrors a through b
        for (int k = 0; k < 3; k++)
          item[6 + k] = bwh_pkg::coord_t'(2 * item[3 + k] - item[k]);
      end else if (kind < 32) begin
        for (int k = 0; k < 3; k++) item[3 + k] = item[k];
      end else if (kind < 40) begin
        // query point sitting on the midpoint of edge ab
        for (int k = 0; k < 3; k++)
          item[9 + k] = bwh_pkg::coord_t'((longint'(item[k]) + longint'(item[3 + k])) >>> 1);
      end else if (kind < 48) begin
        // tiny triangle, point often far: weights can saturate
        for (int k = 3; k < 9; k++) item[k] = near(item[k % 3], 3);
      end
    end
    send(item);
  endtask

  localparam int MX = 32'h7fffffff;
  localparam int MN = 32'h80000000;

  initial begin
    rst_n = 0;
    in_valid = 0;
    hold_req = 0;
    calm = 0;
    sent = 0;
    foreach (tri_in[k]) tri_in[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_coords(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 16384, 16384, 0);
    send_coords(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 0);
    send_coords(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 655360, 655360, 655360);
    send_coords(0, 0, 0, 65536, 0, 0, 131072, 0, 0, 5, 7, 9);
    send_coords(MN, MN, MN, MX, MX, MX, MN, MX, MN, MX, MN, MX);
    send_coords(MN, MN, MN, MX, MN, MN, MN, MX, MN, 0, 0, 0);
    send_coords(MX, MX, MX, MN, MX, MX, MX, MN, MX, MN, MN, MN);
    send_coords(MN, 0, 0, MX, 0, 0, 0, MX, 0, 0, MN, MX);
    send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, MX, MX, MX);
    send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, MN, MN, MN);
    send_coords(-1, -1, -1, 1, 1, 1, 3, 3, 3, 0, 0, 0);
    send_coords(-1, -1, -1, -1, -1, -1, -1, -1, -1, 5, 5, 5);
    send_coords(100, 200, 300, 400, -500, 600, -700, 800, 900, 100, 200, 300);
    send_coords(0, 0, 0, 3, 0, 0, 0, 4, 0, 1, 1, 0);
    send_coords(0, 0, 0, 3, 0, 0, 0, 4, 0, 3, 4, 0);
    send_coords(-65536, 0, 0, 65536, 0, 0, 0, 113512, 0, 0, 37837, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 600) hold_req = 1;
      send_random();
    end
    in_valid <= 1'b0;
    calm = 0;

    wait (backlog == 0 && !out_valid);
    repeat (bwh_pkg::PIPE_LAT + 20) @(posedge clk);
    if (errors == 0 && backlog == 0)
      $display("tb_barycentric_weights_heron_core passed");
    else
      $display("tb_barycentric_weights_heron_core failed");
    $finish;
  end

endmodule
